// ===== design/cbd_pkg.sv =====
// Shared types and constants for the CBOR item stream decoder.
// No dependencies; imported by every module of the block.
package cbd_pkg;

    // Result kinds
    localparam logic [3:0] K_UINT    = 4'd0;
    localparam logic [3:0] K_BSTR    = 4'd1;
    localparam logic [3:0] K_TSTR    = 4'd2;
    localparam logic [3:0] K_ARRAY   = 4'd3;
    localparam logic [3:0] K_MAP     = 4'd4;
    localparam logic [3:0] K_BOOL    = 4'd5;
    localparam logic [3:0] K_NULL    = 4'd6;
    localparam logic [3:0] K_PAYLOAD = 4'd7;
    localparam logic [3:0] K_END     = 4'd8;
    localparam logic [3:0] K_ERROR   = 4'd9;

    // Major types
    localparam logic [2:0] MT_UINT  = 3'd0;
    localparam logic [2:0] MT_NINT  = 3'd1;
    localparam logic [2:0] MT_BSTR  = 3'd2;
    localparam logic [2:0] MT_TSTR  = 3'd3;
    localparam logic [2:0] MT_ARRAY = 3'd4;
    localparam logic [2:0] MT_MAP   = 3'd5;
    localparam logic [2:0] MT_TAG   = 3'd6;
    localparam logic [2:0] MT_OTHER = 3'd7;

    // Initial byte fields and simple values
    localparam logic [7:0] MT_MASK   = 8'h07;
    localparam logic [7:0] AI_MASK   = 8'h1F;
    localparam logic [4:0] AI_DIRECT = 5'd23;
    localparam logic [4:0] AI_ARG1   = 5'd24;
    localparam logic [4:0] AI_ARG8   = 5'd27;
    localparam logic [7:0] SV_FALSE  = 8'hF4;
    localparam logic [7:0] SV_TRUE   = 8'hF5;
    localparam logic [7:0] SV_NULL   = 8'hF6;

    localparam logic [31:0] MAX_ITEMS_RESET = 32'd1024;

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        PH_HEAD = 3'b001,
        PH_ARG  = 3'b010,
        PH_PAY  = 3'b100
    } t_phase;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        logic [7:0]  pbyte;
        logic        run_last;
    } t_result;

    // Results of one input beat, in order
    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

    typedef struct packed {
        logic [QCW-1:0] count;
        logic           full;
    } t_qstat;

endpackage

// ===== design/cbd_parse.sv =====
// Parser state and per-byte decode for the CBOR item stream decoder.
// Depends on cbd_pkg.
module cbd_parse (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_data_byte,
    input  logic           i_last_byte,
    input  logic [31:0]    i_max_items,
    output cbd_pkg::t_push o_push
);
    import cbd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_major, n_major;
    logic [3:0]  r_left,  n_left;
    logic [63:0] r_accum, n_accum;
    logic [63:0] r_plen,  n_plen;
    logic        r_err,   n_err;

    logic        take_vld;
    t_result     take_res;
    logic        head_go;
    logic [2:0]  head_mt;
    logic [63:0] head_v;
    logic [2:0]  mt;
    logic [4:0]  ai;

    assign mt = 3'((i_data_byte >> 5) & MT_MASK);
    assign ai = 5'(i_data_byte & AI_MASK);

    // Decode one byte against the running state
    always_comb begin
        n_phase  = r_phase;
        n_major  = r_major;
        n_left   = r_left;
        n_accum  = r_accum;
        n_plen   = r_plen;
        n_err    = r_err;
        take_vld = 1'b0;
        take_res = '0;
        head_go  = 1'b0;
        head_mt  = r_major;
        head_v   = '0;

        if (!r_err) begin
            case (r_phase)
                PH_ARG: begin
                    n_accum = {r_accum[55:0], i_data_byte};
                    n_left  = (r_left != 4'd0) ? r_left - 4'd1 : 4'd0;
                    if (n_left == 4'd0) begin
                        head_go = 1'b1;
                        head_v  = n_accum;
                    end
                end
                PH_PAY: begin
                    take_vld       = 1'b1;
                    take_res.kind  = K_PAYLOAD;
                    take_res.pbyte = i_data_byte;
                    n_plen = (r_plen != 64'd0) ? r_plen - 64'd1 : 64'd0;
                    if (n_plen == 64'd0) n_phase = PH_HEAD;
                end
                default: begin
                    n_major = mt;
                    n_phase = PH_HEAD;
                    if (mt == MT_NINT || mt == MT_TAG) begin
                        n_err         = 1'b1;
                        take_vld      = 1'b1;
                        take_res.kind = K_ERROR;
                    end else if (mt == MT_OTHER) begin
                        take_vld = 1'b1;
                        if (i_data_byte == SV_FALSE) begin
                            take_res.kind = K_BOOL;
                        end else if (i_data_byte == SV_TRUE) begin
                            take_res.kind  = K_BOOL;
                            take_res.value = 64'd1;
                        end else if (i_data_byte == SV_NULL) begin
                            take_res.kind = K_NULL;
                        end else begin
                            n_err         = 1'b1;
                            take_res.kind = K_ERROR;
                        end
                    end else if (ai <= AI_DIRECT) begin
                        head_go = 1'b1;
                        head_mt = mt;
                        head_v  = 64'(ai);
                    end else if (ai <= AI_ARG8) begin
                        n_left  = 4'd1 << 2'(ai - AI_ARG1);
                        n_accum = '0;
                        n_phase = PH_ARG;
                    end else begin
                        n_err         = 1'b1;
                        take_vld      = 1'b1;
                        take_res.kind = K_ERROR;
                    end
                end
            endcase

            // Close a completed head
            if (head_go) begin
                n_phase  = PH_HEAD;
                take_vld = 1'b1;
                case (head_mt)
                    MT_UINT: begin
                        take_res.kind  = K_UINT;
                        take_res.value = head_v;
                    end
                    MT_BSTR, MT_TSTR: begin
                        take_res.kind  = (head_mt == MT_BSTR) ? K_BSTR : K_TSTR;
                        take_res.value = head_v;
                        if (head_v != 64'd0) begin
                            n_plen  = head_v;
                            n_phase = PH_PAY;
                        end
                    end
                    MT_ARRAY, MT_MAP: begin
                        if (head_v > {32'd0, i_max_items}) begin
                            n_err         = 1'b1;
                            take_res.kind = K_ERROR;
                        end else begin
                            take_res.kind  = (head_mt == MT_ARRAY) ? K_ARRAY : K_MAP;
                            take_res.value = head_v;
                        end
                    end
                    default: begin
                        n_err         = 1'b1;
                        take_res.kind = K_ERROR;
                    end
                endcase
            end
        end
    end

    // Assemble the results of this beat
    always_comb begin
        o_push = '0;
        if (i_last_byte) begin
            if (n_err || n_phase != PH_HEAD) begin
                o_push.n           = 2'd1;
                o_push.r0.kind     = K_ERROR;
                o_push.r0.run_last = 1'b1;
            end else if (take_vld) begin
                o_push.n           = 2'd2;
                o_push.r0          = take_res;
                o_push.r1.kind     = K_END;
                o_push.r1.run_last = 1'b1;
            end else begin
                o_push.n           = 2'd1;
                o_push.r0.kind     = K_END;
                o_push.r0.run_last = 1'b1;
            end
        end else if (take_vld) begin
            o_push.n           = 2'd1;
            o_push.r0          = take_res;
            o_push.r0.run_last = 1'b1;
        end
    end

    // Advance state on each accepted beat; rearm after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD;
            r_major <= '0;
            r_left  <= '0;
            r_accum <= '0;
            r_plen  <= '0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            if (i_last_byte) begin
                r_phase <= PH_HEAD;
                r_major <= '0;
                r_left  <= '0;
                r_accum <= '0;
                r_plen  <= '0;
                r_err   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_major <= n_major;
                r_left  <= n_left;
                r_accum <= n_accum;
                r_plen  <= n_plen;
                r_err   <= n_err;
            end
        end
    end

endmodule

// ===== design/cbd_result_queue.sv =====
// Small result queue: takes up to two results per beat, hands out one.
// Depends on cbd_pkg.
module cbd_result_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_en,
    input  cbd_pkg::t_push   i_push,
    input  logic             i_pop,
    output cbd_pkg::t_result o_head,
    output logic             o_valid,
    output cbd_pkg::t_qstat  o_stat
);
    import cbd_pkg::*;

    t_result        r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0] r_count;
    logic [QCW-1:0] push_n;
    logic [QAW-1:0] wr_next;

    assign push_n  = i_push_en ? QCW'(i_push.n) : '0;
    assign wr_next = r_wr_ptr + QAW'(1);

    assign o_valid     = (r_count != '0);
    assign o_head      = r_mem[r_rd_ptr];
    assign o_stat.count = r_count;
    // Leave room for the largest beat
    assign o_stat.full  = (r_count > QCW'(QDEPTH - 2));

    // Store results of the beat
    always_ff @(posedge i_clk) begin
        if (push_n != '0) r_mem[r_wr_ptr] <= i_push.r0;
        if (push_n == QCW'(2)) r_mem[wr_next] <= i_push.r1;
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QAW'(push_n);
            if (i_pop) r_rd_ptr <= r_rd_ptr + QAW'(1);
            r_count <= r_count + push_n - QCW'(i_pop);
        end
    end

endmodule

// ===== design/cbor_item_stream_decoder_core.sv =====
// Top level of the CBOR item stream decoder: config register, parser, result queue.
// Depends on cbd_pkg, cbd_parse and cbd_result_queue.

// Accepts one buffer byte per clock and emits one result beat per clock while the
// output is not stalled. Each byte is decoded by the parser, whose results (none,
// one or two) enter a four-entry result queue; the input stalls only while that
// queue lacks room for two results, so with an unstalled output a byte stream
// whose bytes each give at most one result runs at one byte per cycle, and only
// a final byte that closes an item gives two results (item result plus end).
// Results are uint, string heads, array and map counts, booleans, null, one
// payload beat per string byte, errors, and one end or error beat on the final
// byte. The count limit register may be written only while the block is idle.
module cbor_item_stream_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_kind,
    output logic [63:0] o_value,
    output logic [7:0]  o_payload_byte,
    output logic        o_run_last,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    import cbd_pkg::*;

    logic [31:0] r_max_items;
    logic        in_accept;
    logic        out_pop;
    t_push       push;
    t_result     head;
    t_qstat      qstat;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_pop    = o_out_valid && !i_out_stall;
    assign o_in_stall = qstat.full;

    // Hold the container count limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_items <= MAX_ITEMS_RESET;
        end else if (i_cfg_we) begin
            r_max_items <= i_cfg_wdata;
        end
    end

    cbd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_max_items (r_max_items),
        .o_push      (push)
    );

    cbd_result_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (in_accept),
        .i_push    (push),
        .i_pop     (out_pop),
        .o_head    (head),
        .o_valid   (o_out_valid),
        .o_stat    (qstat)
    );

    assign o_kind         = head.kind;
    assign o_value        = head.value;
    assign o_payload_byte = head.pbyte;
    assign o_run_last     = head.run_last;

    // Queue never overfills
    a_qbound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.count <= QCW'(QDEPTH))
        else $error("result queue overfilled");

    // Accepted beat without a pop grows the queue by its result count
    a_qgrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !out_pop) |=>
            qstat.count == $past(qstat.count) + QCW'($past(push.n)))
        else $error("result queue lost or gained entries");

    // End and error beats always close their input byte
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == K_END || o_kind == K_ERROR)) |-> o_run_last)
        else $error("end or error beat without run_last");

endmodule

// ===== test/cbor_item_stream_decoder_core_tb.sv =====
// Self-checking testbench for cbor_item_stream_decoder_core: random CBOR buffers,
// a cycle-free predictor of the decoder and a scoreboard of result beats.
// Depends on cbd_pkg and the decoder RTL.
module cbor_item_stream_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbd_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [1:0] {
        AWAIT_HEAD,
        GATHER_ARG,
        COPY_PAYLOAD
    } t_dec_phase;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_in_beat;

    // DUT inputs, known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  in_data = 8'd0;
    logic        in_last = 1'b0;
    logic        out_stall = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = 32'd0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [3:0]  o_kind;
    logic [63:0] o_value;
    logic [7:0]  o_payload_byte;
    logic        o_run_last;

    // Stimulus and scoreboard storage
    t_in_beat    byte_q[$];
    t_result     exp_results[$];
    logic [7:0]  frame[$];
    logic        in_taken = 1'b0;
    logic        calm = 1'b0;
    int          mismatches = 0;
    int          stuck = 0;
    int          sent = 0;

    // Shadow of the decoder state and its limit register
    t_dec_phase  dec_phase = AWAIT_HEAD;
    logic [2:0]  dec_major = '0;
    logic [3:0]  dec_arg_left = '0;
    logic [63:0] dec_accum = '0;
    logic [63:0] dec_pay_left = '0;
    logic        dec_err = 1'b0;
    logic [31:0] cnt_limit = MAX_ITEMS_RESET;
    t_result     beat_res[2];
    int          beat_nres;

    cbor_item_stream_decoder_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (in_data),
        .i_last_byte    (in_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_kind         (o_kind),
        .o_value        (o_value),
        .o_payload_byte (o_payload_byte),
        .o_run_last     (o_run_last),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    task automatic note_result(input logic [3:0] kind, input logic [63:0] value,
                               input logic [7:0] pbyte);
        if (beat_nres < 2) begin
            beat_res[beat_nres] = '{kind: kind, value: value, pbyte: pbyte, run_last: 1'b0};
            beat_nres++;
        end
    endtask

    task automatic flag_error();
        dec_err = 1'b1;
        dec_phase = AWAIT_HEAD;
        note_result(K_ERROR, 64'd0, 8'd0);
    endtask

    task automatic close_head(input logic [63:0] v);
        dec_phase = AWAIT_HEAD;
        case (dec_major)
            MT_UINT: begin
                note_result(K_UINT, v, 8'd0);
            end
            MT_BSTR, MT_TSTR: begin
                note_result((dec_major == MT_BSTR) ? K_BSTR : K_TSTR, v, 8'd0);
                if (v != 64'd0) begin
                    dec_pay_left = v;
                    dec_phase = COPY_PAYLOAD;
                end
            end
            MT_ARRAY, MT_MAP: begin
                if (v > {32'd0, cnt_limit})
                    flag_error();
                else
                    note_result((dec_major == MT_ARRAY) ? K_ARRAY : K_MAP, v, 8'd0);
            end
            default: begin
                flag_error();
            end
        endcase
    endtask

    // Decode one accepted byte and queue the result beats it causes
    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [2:0] mt;
        logic [4:0] ai;
        logic       was_err;
        was_err = dec_err;
        beat_nres = 0;
        if (!was_err) begin
            case (dec_phase)
                GATHER_ARG: begin
                    dec_accum = {dec_accum[55:0], b};
                    if (dec_arg_left != 4'd0)
                        dec_arg_left--;
                    if (dec_arg_left == 4'd0)
                        close_head(dec_accum);
                end
                COPY_PAYLOAD: begin
                    note_result(K_PAYLOAD, 64'd0, b);
                    if (dec_pay_left != 64'd0)
                        dec_pay_left--;
                    if (dec_pay_left == 64'd0)
                        dec_phase = AWAIT_HEAD;
                end
                default: begin
                    mt = 3'((b >> 5) & MT_MASK);
                    ai = 5'(b & AI_MASK);
                    dec_major = mt;
                    if (mt == MT_NINT || mt == MT_TAG) begin
                        flag_error();
                    end else if (mt == MT_OTHER) begin
                        dec_phase = AWAIT_HEAD;
                        if (b == SV_FALSE)
                            note_result(K_BOOL, 64'd0, 8'd0);
                        else if (b == SV_TRUE)
                            note_result(K_BOOL, 64'd1, 8'd0);
                        else if (b == SV_NULL)
                            note_result(K_NULL, 64'd0, 8'd0);
                        else
                            flag_error();
                    end else if (ai <= AI_DIRECT) begin
                        close_head(64'(ai));
                    end else if (ai <= AI_ARG8) begin
                        dec_arg_left = 4'(1 << (ai - AI_ARG1));
                        dec_accum = 64'd0;
                        dec_phase = GATHER_ARG;
                    end else begin
                        flag_error();
                    end
                end
            endcase
        end
        // Final byte: end if clean, otherwise a lone error; then re-arm
        if (last) begin
            if (dec_err || dec_phase != AWAIT_HEAD) begin
                beat_nres = 0;
                note_result(K_ERROR, 64'd0, 8'd0);
            end else begin
                note_result(K_END, 64'd0, 8'd0);
            end
            dec_phase = AWAIT_HEAD;
            dec_major = '0;
            dec_arg_left = '0;
            dec_accum = '0;
            dec_pay_left = '0;
            dec_err = 1'b0;
        end
        if (beat_nres > 0)
            beat_res[beat_nres - 1].run_last = 1'b1;
        for (int i = 0; i < beat_nres; i++)
            exp_results.push_back(beat_res[i]);
    endtask

    // ---------------------------------------------------------------- driver

    // Present the head of the byte queue; hold a beat until it is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_taken) begin
            // hold
        end else if (byte_q.size() != 0 && (calm || $urandom_range(0, 99) >= 22)) begin
            in_valid <= 1'b1;
            in_data <= byte_q[0].data;
            in_last <= byte_q[0].last;
        end else begin
            in_valid <= 1'b0;
        end
        out_stall <= !calm && ($urandom_range(0, 99) < 22);
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        logic    moved;
        in_taken = 1'b0;
        moved = 1'b0;
        if (i_rst_n) begin
            // Input beat accepted: predict before checking outputs
            if (in_valid && !o_in_stall) begin
                in_taken = 1'b1;
                moved = 1'b1;
                decode_byte(byte_q[0].data, byte_q[0].last);
                void'(byte_q.pop_front());
            end
            // Output beat accepted: compare with the oldest expectation
            if (o_out_valid && !out_stall) begin
                moved = 1'b1;
                got = '{kind: o_kind, value: o_value, pbyte: o_payload_byte,
                        run_last: o_run_last};
                if (exp_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: kind=%0d value=%0h pbyte=%02h last=%0b",
                                 got.kind, got.value, got.pbyte, got.run_last);
                end else begin
                    want = exp_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("mismatch: exp kind=%0d value=%0h pbyte=%02h last=%0b",
                                   want.kind, want.value, want.pbyte, want.run_last);
                            $display(" got kind=%0d value=%0h pbyte=%02h last=%0b",
                                     got.kind, got.value, got.pbyte, got.run_last);
                        end
                    end
                end
            end
            // Watchdog on cycles without any accepted beat
            if (moved)
                stuck = 0;
            else
                stuck++;
            if (stuck >= STUCK_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", STUCK_LIMIT);
                $display("cbor_item_stream_decoder_core_tb NOT OK");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic push_frame();
        for (int i = 0; i < frame.size(); i++) begin
            byte_q.push_back('{data: frame[i], last: (i == frame.size() - 1)});
            sent++;
        end
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (byte_q.size() != 0 || exp_results.size() != 0);
    endtask

    task automatic set_limit(input logic [31:0] v);
        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        cnt_limit = v;
    endtask

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 4))
            0:       return 64'($urandom_range(0, 23));
            1:       return 64'($urandom_range(0, 255));
            2:       return 64'($urandom_range(0, 65535));
            3:       return 64'($urandom);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Append a head: mostly direct form when it fits, else a sized argument, sometimes wider
    task automatic add_head(input logic [2:0] mt, input logic [63:0] v);
        int nb;
        logic [4:0] ai;
        if (v < 64'd24 && $urandom_range(0, 3) != 0) begin
            frame.push_back({mt, v[4:0]});
        end else begin
            nb = (v < 64'd256) ? 1 : (v < 64'd65536) ? 2 : (v < 64'h1_0000_0000) ? 4 : 8;
            if (nb < 8 && $urandom_range(0, 5) == 0)
                nb = nb * 2;
            case (nb)
                1:       ai = AI_ARG1;
                2:       ai = AI_ARG1 + 5'd1;
                4:       ai = AI_ARG1 + 5'd2;
                default: ai = AI_ARG8;
            endcase
            frame.push_back({mt, ai});
            for (int i = nb - 1; i >= 0; i--)
                frame.push_back(v[8*i +: 8]);
        end
    endtask

    // Build one buffer of random items, mostly well formed
    task automatic gen_frame();
        int n;
        int sel;
        int len;
        logic [63:0] cnt;
        logic [2:0] mt;
        frame.delete();
        if ($urandom_range(0, 99) < 8) begin
            // noise buffer
            n = $urandom_range(1, 8);
            repeat (n) frame.push_back(8'($urandom));
        end else begin
            n = $urandom_range(1, 5);
            repeat (n) begin
                sel = $urandom_range(0, 99);
                if (sel < 25) begin
                    add_head(MT_UINT, pick_value());
                end else if (sel < 45) begin
                    len = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 6)
                                                       : $urandom_range(7, 40);
                    add_head($urandom_range(0, 1) ? MT_BSTR : MT_TSTR, 64'(len));
                    repeat (len) frame.push_back(8'($urandom));
                end else if (sel < 65) begin
                    case ($urandom_range(0, 4))
                        0:       cnt = 64'd0;
                        1:       cnt = {32'd0, cnt_limit};
                        2:       cnt = {32'd0, cnt_limit} + 64'd1;
                        3:       cnt = 64'($urandom_range(0, 8));
                        default: cnt = pick_value();
                    endcase
                    add_head($urandom_range(0, 1) ? MT_ARRAY : MT_MAP, cnt);
                end else if (sel < 80) begin
                    case ($urandom_range(0, 2))
                        0:       frame.push_back(SV_FALSE);
                        1:       frame.push_back(SV_TRUE);
                        default: frame.push_back(SV_NULL);
                    endcase
                end else if (sel < 88) begin
                    case ($urandom_range(0, 3))
                        0: frame.push_back({MT_NINT, 5'($urandom)});
                        1: frame.push_back({MT_TAG, 5'($urandom)});
                        2: frame.push_back({MT_OTHER, 5'($urandom)});
                        default: begin
                            case ($urandom_range(0, 4))
                                0:       mt = MT_UINT;
                                1:       mt = MT_BSTR;
                                2:       mt = MT_TSTR;
                                3:       mt = MT_ARRAY;
                                default: mt = MT_MAP;
                            endcase
                            frame.push_back({mt, AI_ARG8 + 5'($urandom_range(1, 4))});
                        end
                    endcase
                end else begin
                    frame.push_back(8'($urandom));
                end
            end
            // Sometimes cut the buffer short inside an item
            if (frame.size() > 1 && $urandom_range(0, 99) < 12) begin
                len = $urandom_range(1, frame.size() - 1);
                repeat (len) void'(frame.pop_back());
            end
        end
    endtask

    task automatic run_phase(input logic [31:0] lim, input int n_items, input logic quiet);
        int goal;
        set_limit(lim);
        calm = quiet;
        goal = sent + n_items;
        while (sent < goal) begin
            gen_frame();
            push_frame();
        end
        wait_idle();
        calm = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed buffers at the reset limit
        frame = '{8'h00};                                       push_frame();
        frame = '{8'h17, 8'h18, 8'hFF, SV_FALSE, SV_TRUE, SV_NULL};
        push_frame();
        frame = '{8'h1B, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        push_frame();
        // string whose last payload byte closes the buffer
        frame = '{8'h42, 8'hAA, 8'h55};                         push_frame();
        // unsupported items, each alone
        frame = '{8'h20};                                       push_frame();
        frame = '{8'hC0};                                       push_frame();
        frame = '{8'hF9};                                       push_frame();
        frame = '{8'hE0};                                       push_frame();
        frame = '{8'h1C};                                       push_frame();
        frame = '{8'h1F};                                       push_frame();
        // array count one over the limit, error then quiet bytes
        frame = '{8'h99, 8'h04, 8'h01, 8'h01};                  push_frame();
        // buffer ending inside an argument, and a string head on the final byte
        frame = '{8'h19, 8'h01};                                push_frame();
        frame = '{8'h61};                                       push_frame();
        frame = '{8'h80, 8'hA0};                                push_frame();
        wait_idle();

        // Random buffers across limit settings, extremes included
        run_phase(32'd0, 300, 1'b0);
        run_phase(32'hFFFF_FFFF, 300, 1'b0);
        run_phase(32'($urandom_range(1, 8)), 400, 1'b1);
        run_phase(MAX_ITEMS_RESET, 400, 1'b0);
        run_phase($urandom, 300, 1'b0);
        run_phase(32'd1, 250, 1'b0);

        repeat (20) @(posedge i_clk);
        #1;
        if (exp_results.size() != 0) begin
            mismatches++;
            $display("%0d expected beats never arrived", exp_results.size());
        end
        if (mismatches == 0)
            $display("cbor_item_stream_decoder_core_tb OK");
        else
            $display("cbor_item_stream_decoder_core_tb NOT OK");
        $finish;
    end

endmodule
